// ----- rtl/cwrs_pkg.sv -----
// Package for the cosine warmup rate schedule: phase and register codes,
// pipeline sizes and the decay-factor ROM builder. No dependencies.
`default_nettype none
package cwrs_pkg;

  localparam int PHASE_BITS = 10;
  localparam int ROM_DEPTH  = 1 << PHASE_BITS;
  localparam int DIV_STAGES = 32;
  localparam int LATENCY    = DIV_STAGES + 5;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  typedef enum logic [1:0] {
    PH_WARMUP  = 2'd0,
    PH_DECAY   = 2'd1,
    PH_FLOOR   = 2'd2,
    PH_INVALID = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    REG_PEAK  = 2'd0,
    REG_FLOOR = 2'd1,
    REG_RAMP  = 2'd2,
    REG_SCHED = 2'd3
  } reg_idx_t;

  typedef logic [30:0] rom_t [ROM_DEPTH];

  function automatic logic [63:0] sat_one_minus(input logic [63:0] term);
    return (term >= Q30_ONE) ? 64'd0 : Q30_ONE - term;
  endfunction

  function automatic logic [63:0] cos_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] acc;
    x2  = (x * x) >> 30;
    acc = Q30_ONE;
    acc = sat_one_minus(((acc * x2) >> 30) / 64'd182);
    acc = sat_one_minus(((acc * x2) >> 30) / 64'd132);
    acc = sat_one_minus(((acc * x2) >> 30) / 64'd90);
    acc = sat_one_minus(((acc * x2) >> 30) / 64'd56);
    acc = sat_one_minus(((acc * x2) >> 30) / 64'd30);
    acc = sat_one_minus(((acc * x2) >> 30) / 64'd12);
    acc = sat_one_minus(((acc * x2) >> 30) / 64'd2);
    return acc;
  endfunction

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] c;
    logic [63:0] n;
    n = 64'(ROM_DEPTH);
    for (int p = 0; p < ROM_DEPTH; p++) begin
      if (2 * p <= ROM_DEPTH) begin
        c = cos_q30((PI_Q30 * 64'(p)) >> PHASE_BITS);
        r[p] = 31'((Q30_ONE + c) >> 1);
      end else begin
        c = cos_q30((PI_Q30 * (n - 64'(p))) >> PHASE_BITS);
        r[p] = 31'(sat_one_minus(c) >> 1);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/cosine_warmup_rate_schedule.sv -----
// Top level of the cosine warmup rate schedule: classify, divide, ROM, scale.
// Depends on cwrs_pkg.
//
// Usage:
//   Input channel: a step word is taken at each clock edge with start high
//   and busy low. busy is always low, so a step can enter every cycle.
//   Output channel: done pulses for one cycle with rate and phase; the
//   receiver takes it in that cycle and cannot hold it off.
//   Config port: write_enable, write_index, write_data; a register is written
//   at the edge with write_enable high. Write only while the pipeline is empty.
//   Results: one per step; a step passes the classify, divider, ROM, scale and output registers.
//   Throughput: one step per cycle. Depth is set by the 32-stage restoring
//   divider (one quotient bit per stage) that serves both the warmup quotient
//   and the decay progress.
//   Reset (rst, synchronous): clears all valid bits and loads the register
//   defaults; words in flight are dropped.
`default_nettype none
module cosine_warmup_rate_schedule (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [31:0]              step_number,
  input  wire logic                     write_enable,
  input  wire cwrs_pkg::reg_idx_t       write_index,
  input  wire logic [31:0]              write_data,
  output logic                          done,
  output logic [31:0]                   rate,
  output logic [1:0]                    phase
);
  import cwrs_pkg::*;

  localparam rom_t DECAY_ROM = build_rom();

  logic [31:0] peak_rate, floor_rate, ramp_length, schedule_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_rate       <= 32'd322122;
      floor_rate      <= 32'd0;
      ramp_length     <= 32'd0;
      schedule_length <= 32'd1;
    end else if (write_enable) begin
      unique case (write_index)
        REG_PEAK:  peak_rate       <= write_data;
        REG_FLOOR: floor_rate      <= write_data;
        REG_RAMP:  ramp_length     <= write_data;
        REG_SCHED: schedule_length <= write_data;
        default:   ;
      endcase
    end
  end

  assign busy = 1'b0;

  // classify
  logic [31:0] stp;
  logic        cfg_bad;
  phase_t      ph_next;

  always_comb begin
    stp     = step_number[31] ? 32'd0 : step_number;
    cfg_bad = (peak_rate == 32'd0) || (floor_rate > peak_rate) ||
              (ramp_length >= schedule_length);
    priority if (cfg_bad)                  ph_next = PH_INVALID;
    else if (stp < ramp_length)            ph_next = PH_WARMUP;
    else if (stp >= schedule_length)       ph_next = PH_FLOOR;
    else                                   ph_next = PH_DECAY;
  end

  logic        a_vld;
  phase_t      a_ph;
  logic [31:0] a_step, a_num, a_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start && !busy;
    end
    a_ph   <= ph_next;
    a_step <= stp;
    a_num  <= stp - ramp_length;
    a_den  <= schedule_length - ramp_length;
  end

  // dividend setup
  logic [63:0] dvd;
  logic [31:0] dsr;

  always_comb begin
    if (a_ph == PH_WARMUP) begin
      dvd = 64'(peak_rate) * 64'(a_step);
      dsr = ramp_length;
    end else begin
      dvd = 64'(a_num) << PHASE_BITS;
      dsr = a_den;
    end
  end

  logic [DIV_STAGES:0] dv_vld;
  phase_t              dv_ph  [DIV_STAGES+1];
  logic [31:0]         dv_rem [DIV_STAGES+1];
  logic [31:0]         dv_lo  [DIV_STAGES+1];
  logic [31:0]         dv_q   [DIV_STAGES+1];
  logic [31:0]         dv_dsr [DIV_STAGES+1];

  logic [32:0] trial    [DIV_STAGES];
  logic [32:0] diff     [DIV_STAGES];
  logic        ge       [DIV_STAGES];
  logic [31:0] rem_next [DIV_STAGES];

  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      trial[k]    = {dv_rem[k], dv_lo[k][31]};
      diff[k]     = trial[k] - {1'b0, dv_dsr[k]};
      ge[k]       = trial[k] >= {1'b0, dv_dsr[k]};
      rem_next[k] = ge[k] ? diff[k][31:0] : trial[k][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld <= '0;
    end else begin
      dv_vld <= {dv_vld[DIV_STAGES-1:0], a_vld};
    end
    dv_ph[0]  <= a_ph;
    dv_rem[0] <= dvd[63:32];
    dv_lo[0]  <= dvd[31:0];
    dv_q[0]   <= 32'd0;
    dv_dsr[0] <= dsr;
    for (int k = 0; k < DIV_STAGES; k++) begin
      dv_ph[k+1]  <= dv_ph[k];
      dv_rem[k+1] <= rem_next[k];
      dv_lo[k+1]  <= {dv_lo[k][30:0], 1'b0};
      dv_q[k+1]   <= {dv_q[k][30:0], ge[k]};
      dv_dsr[k+1] <= dv_dsr[k];
    end
  end

  // ROM read
  logic        r_vld;
  phase_t      r_ph;
  logic [31:0] r_q;
  logic [30:0] r_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else begin
      r_vld <= dv_vld[DIV_STAGES];
    end
    r_ph <= dv_ph[DIV_STAGES];
    r_q  <= dv_q[DIV_STAGES];
    r_f  <= DECAY_ROM[dv_q[DIV_STAGES][PHASE_BITS-1:0]];
  end

  // scale
  logic        m_vld;
  phase_t      m_ph;
  logic [31:0] m_q;
  logic [62:0] m_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= r_vld;
    end
    m_ph   <= r_ph;
    m_q    <= r_q;
    m_prod <= 63'(peak_rate - floor_rate) * 63'(r_f);
  end

  // result select
  logic [32:0] decay_sum;
  logic [31:0] rate_next;

  always_comb begin
    decay_sum = {1'b0, floor_rate} + m_prod[62:30];
    unique case (m_ph)
      PH_WARMUP:  rate_next = m_q;
      PH_DECAY:   rate_next = decay_sum[31:0];
      PH_FLOOR:   rate_next = floor_rate;
      PH_INVALID: rate_next = 32'd0;
      default:    rate_next = 32'd0;
    endcase
  end

  logic   o_vld;
  phase_t o_ph;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else begin
      o_vld <= m_vld;
    end
    o_ph <= m_ph;
    rate <= rate_next;
  end

  assign done  = o_vld;
  assign phase = o_ph;

endmodule
`default_nettype wire

// ----- rtl/cwrs_checker.sv -----
// Port-level checker for the cosine warmup rate schedule, bound to the top.
// Depends on cwrs_pkg.
`default_nettype none
module cwrs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [31:0] rate,
  input wire logic [1:0]  phase
);
  import cwrs_pkg::*;

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result word without a step word");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && phase == PH_INVALID) |-> rate == 32'd0)
    else $error("invalid config gives nonzero rate");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result word right after reset");

endmodule

bind cosine_warmup_rate_schedule cwrs_checker u_cwrs_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy),
  .done(done), .rate(rate), .phase(phase)
);
`default_nettype wire

// ----- test/testbench.sv -----
// Testbench for cosine_warmup_rate_schedule: directed table, then randomized
// schedules, each result checked against an in-bench predictor. Uses cwrs_pkg.
module testbench;
  import cwrs_pkg::*;

  localparam int LIMIT = 400000;

  typedef struct {
    logic [31:0] rate;
    phase_t      phase;
  } sched_word_t;

  typedef struct {
    bit          cfg;
    logic [31:0] peak, flr, ramp, sched;
    logic [31:0] step;
    bit          typed;
    logic [31:0] rate;
    phase_t      phase;
  } row_t;

  logic        clk, rst, start, write_enable;
  logic [31:0] step_number, write_data;
  reg_idx_t    write_index;
  logic        busy, done;
  logic [31:0] rate;
  logic [1:0]  phase;

  cosine_warmup_rate_schedule dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .step_number(step_number),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data),
    .done(done), .rate(rate), .phase(phase)
  );

  logic [63:0] half_cos_tab [ROM_DEPTH];
  logic [63:0] peak_r, floor_r, ramp_r, sched_r;
  sched_word_t pending_rates [$];
  int          errors, cycles, taken, results, n_warm, n_decay, n_floor, n_bad;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [63:0] one_minus(input logic [63:0] t);
    return (t >= Q30_ONE) ? 64'd0 : Q30_ONE - t;
  endfunction

  function automatic logic [63:0] cos_series(input logic [63:0] x);
    logic [63:0] dv [7];
    logic [63:0] sq, acc;
    dv = '{64'd182, 64'd132, 64'd90, 64'd56, 64'd30, 64'd12, 64'd2};
    sq = (x * x) >> 30;
    acc = Q30_ONE;
    for (int i = 0; i < 7; i++) acc = one_minus(((acc * sq) >> 30) / dv[i]);
    return acc;
  endfunction

  function automatic sched_word_t rate_for_step(input logic [31:0] raw);
    sched_word_t w;
    logic [63:0] s, p, f;
    s = raw[31] ? 64'd0 : {32'd0, raw};
    if (peak_r == 0 || floor_r > peak_r || ramp_r >= sched_r) begin
      w.rate = '0; w.phase = PH_INVALID;
    end else if (s < ramp_r) begin
      w.rate = 32'((peak_r * s) / ramp_r); w.phase = PH_WARMUP;
    end else if (s >= sched_r) begin
      w.rate = floor_r[31:0]; w.phase = PH_FLOOR;
    end else begin
      p = ((s - ramp_r) << PHASE_BITS) / (sched_r - ramp_r);
      f = half_cos_tab[p];
      w.rate = 32'(floor_r + (((peak_r - floor_r) * f) >> 30));
      w.phase = PH_DECAY;
    end
    return w;
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= 40) $display("ERROR @%0d: %s", cycles, msg);
  endtask

  always @(posedge clk) begin
    sched_word_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (!rst) begin
      if (start && !busy) begin
        pending_rates.push_back(rate_for_step(step_number));
        taken <= taken + 1;
      end
      if (done) begin
        results++;
        if (pending_rates.size() == 0) report("result with nothing pending");
        else begin
          e = pending_rates.pop_front();
          case (phase)
            PH_WARMUP: n_warm++;
            PH_DECAY:  n_decay++;
            PH_FLOOR:  n_floor++;
            default:   n_bad++;
          endcase
          if (rate !== e.rate)
            report($sformatf("rate %h, want %h", rate, e.rate));
          if (phase !== e.phase)
            report($sformatf("phase %0d, want %0d", phase, e.phase));
        end
      end
      if (write_enable)
        case (write_index)
          REG_PEAK:  peak_r  = {32'd0, write_data};
          REG_FLOOR: floor_r = {32'd0, write_data};
          REG_RAMP:  ramp_r  = {32'd0, write_data};
          REG_SCHED: sched_r = {32'd0, write_data};
        endcase
    end
  end

  task automatic drain();
    start = 1'b0;
    while (pending_rates.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic load_schedule(input logic [31:0] pk, fl, rp, sc);
    logic [31:0] v [4];
    v = '{pk, fl, rp, sc};
    drain();
    for (int i = 0; i < 4; i++) begin
      write_enable = 1'b1;
      write_index = reg_idx_t'(i);
      write_data = v[i];
      @(negedge clk);
    end
    write_enable = 1'b0;
  endtask

  task automatic send(input logic [31:0] s, input int gap);
    int n;
    start = 1'b1;
    step_number = s;
    n = taken;
    do @(negedge clk); while (taken == n);
    if (gap > 0) begin
      start = 1'b0;
      step_number = $urandom;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic int pick_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  row_t dir [$];

  function automatic row_t mk(input bit c, input logic [31:0] pk, fl, rp, sc, s,
                              input bit t, input logic [31:0] r, input phase_t ph);
    row_t x;
    x = '{c, pk, fl, rp, sc, s, t, r, ph};
    return x;
  endfunction

  initial begin
    logic [31:0] pk, fl, rp, sc, s;
    logic [63:0] hi;
    bit          steady;
    for (int p = 0; p < ROM_DEPTH; p++)
      if (2 * p <= ROM_DEPTH)
        half_cos_tab[p] = (Q30_ONE + cos_series((PI_Q30 * 64'(p)) >> PHASE_BITS)) >> 1;
      else
        half_cos_tab[p] =
          one_minus(cos_series((PI_Q30 * (64'(ROM_DEPTH) - 64'(p))) >> PHASE_BITS)) >> 1;
    peak_r = 64'd322122; floor_r = 0; ramp_r = 0; sched_r = 64'd1;
    errors = 0; cycles = 0; taken = 0; results = 0;
    n_warm = 0; n_decay = 0; n_floor = 0; n_bad = 0;
    rst = 1'b1; start = 1'b0; step_number = '0;
    write_enable = 1'b0; write_index = REG_PEAK; write_data = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    dir.push_back(mk(0, 0, 0, 0, 0, 0, 1, 322122, PH_DECAY));
    dir.push_back(mk(0, 0, 0, 0, 0, 32'hffffffff, 1, 322122, PH_DECAY));
    dir.push_back(mk(0, 0, 0, 0, 0, 32'h80000000, 1, 322122, PH_DECAY));
    dir.push_back(mk(0, 0, 0, 0, 0, 1, 1, 0, PH_FLOOR));
    dir.push_back(mk(0, 0, 0, 0, 0, 32'h7fffffff, 1, 0, PH_FLOOR));
    dir.push_back(mk(1, 0, 0, 0, 10, 3, 1, 0, PH_INVALID));
    dir.push_back(mk(1, 100, 200, 0, 10, 3, 1, 0, PH_INVALID));
    dir.push_back(mk(1, 1 << 30, 0, 10, 10, 3, 1, 0, PH_INVALID));
    dir.push_back(mk(1, 1 << 30, 0, 0, 0, 0, 1, 0, PH_INVALID));
    dir.push_back(mk(1, 1 << 30, 1 << 20, 100, 1100, 0, 1, 0, PH_WARMUP));
    dir.push_back(mk(0, 0, 0, 0, 0, 50, 1, 1 << 29, PH_WARMUP));
    dir.push_back(mk(0, 0, 0, 0, 0, 99, 0, 0, PH_WARMUP));
    dir.push_back(mk(0, 0, 0, 0, 0, 100, 1, 1 << 30, PH_DECAY));
    dir.push_back(mk(0, 0, 0, 0, 0, 600, 0, 0, PH_DECAY));
    dir.push_back(mk(0, 0, 0, 0, 0, 1099, 0, 0, PH_DECAY));
    dir.push_back(mk(0, 0, 0, 0, 0, 1100, 1, 1 << 20, PH_FLOOR));
    dir.push_back(mk(0, 0, 0, 0, 0, -5, 1, 0, PH_WARMUP));
    dir.push_back(mk(1, '1, '1, 32'hfffffffe, '1, 32'hfffffffe, 1, 0, PH_WARMUP));
    dir.push_back(mk(0, 0, 0, 0, 0, 32'h7fffffff, 0, 0, PH_WARMUP));
    dir.push_back(mk(1, '1, 0, 0, '1, 0, 1, '1, PH_DECAY));
    dir.push_back(mk(0, 0, 0, 0, 0, 32'h7fffffff, 0, 0, PH_DECAY));

    foreach (dir[i]) begin
      if (dir[i].cfg) load_schedule(dir[i].peak, dir[i].flr, dir[i].ramp, dir[i].sched);
      if (dir[i].typed) begin
        drain();
        if (rate_for_step(dir[i].step).rate !== dir[i].rate ||
            rate_for_step(dir[i].step).phase !== dir[i].phase)
          report($sformatf("table row %0d disagrees with predictor", i));
      end
      send(dir[i].step, pick_gap(0));
    end
    start = 1'b0;

    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 9))
        0: begin pk = $urandom; fl = $urandom; rp = $urandom; sc = $urandom; end
        1: begin pk = '1; fl = 0; rp = $urandom_range(0, 32'h7fff0000);
                 sc = $urandom_range(rp + 1, 32'hffffffff); end
        default: begin
          pk = $urandom | 32'd1; fl = $urandom_range(0, pk);
          rp = $urandom_range(0, 2000); sc = rp + $urandom_range(1, 5000);
        end
      endcase
      if (ph == 0) begin pk = '1; fl = '1; rp = 0; sc = '1; end
      load_schedule(pk, fl, rp, sc);
      steady = ($urandom_range(0, 3) == 0);
      hi = 64'(sc) + 64'd10;
      if (hi > 64'h7fffffff) hi = 64'h7fffffff;
      for (int k = 0; k < 100; k++) begin
        case ($urandom_range(0, 9))
          0: s = $urandom;
          1: s = 32'h80000000 | $urandom;
          2: s = $urandom_range(0, rp);
          default: s = $urandom_range(0, hi[31:0]);
        endcase
        send(s, pick_gap(steady));
      end
      start = 1'b0;
    end

    drain();
    repeat (LATENCY + 5) @(negedge clk);
    if (pending_rates.size() != 0) report("results still pending at end");
    $display("%0d steps, %0d rates checked: warmup %0d, decay %0d, floor %0d, invalid %0d",
             taken, results, n_warm, n_decay, n_floor, n_bad);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
